/* hw/rtl/pixel_config_portal_regs_core_defines.svh */
// assertion macros used by the datapath rtl file (pcpr_dp.sv)
`ifndef PIXEL_CONFIG_PORTAL_REGS_CORE_DEFINES_SVH
`define PIXEL_CONFIG_PORTAL_REGS_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PCPR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pcpr check failed");

// next-cycle implication
`define PCPR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pcpr check failed");

`else

`define PCPR_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define PCPR_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* hw/rtl/pcpr_pkg.sv */
package pcpr_pkg;

	// parameter defaults
	localparam int ROWS_DEF            = 384;
	localparam int DOUBLE_COLUMNS_DEF  = 200;
	localparam int CORE_COLUMNS_DEF    = 50;
	localparam int COLUMN_REG_ADDR_DEF = 2;
	localparam int ROW_REG_ADDR_DEF    = 3;

	// fixed field widths
	localparam int ADDR_W     = 10;
	localparam int DATA_W     = 16;
	localparam int WORD_W     = 32;
	localparam int REG_AW     = 9;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 9;
	localparam int BCOL_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam int GLOBAL_DEPTH = 512;

	// service block constants
	localparam logic [7:0] SERVICE_TAG = 8'h99;
	localparam logic [1:0] STATUS_OK   = 2'b00;

	// command function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_TDAC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ROW    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ID     = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MRD,
		ST_MWR,
		ST_RDWAIT
	} state_t;

	typedef enum logic [1:0] {
		OP_GWRITE,
		OP_PFULL,
		OP_PMULTI,
		OP_READ
	} op_t;

	typedef struct packed {
		logic take_item;
		logic clr_step;
		logic exec;
		logic mw_read;
		logic mw_write;
		logic load_out;
		logic adv_row;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		op_t  op;
		logic portal;
		logic mw_last;
		logic out_free;
	} sts_t;

	// mask multi-write: pair bits 10..8 <- data 7..5, pair bits 2..0 <- data 2..0
	function automatic logic [DATA_W-1:0] mask_merge(logic [DATA_W-1:0] v,
			logic [DATA_W-1:0] d);
		return {v[15:11], d[7:5], v[7:3], d[2:0]};
	endfunction

	// tdac multi-write: pair bits 15..11 <- data 9..5, pair bits 7..3 <- data 4..0
	function automatic logic [DATA_W-1:0] tdac_merge(logic [DATA_W-1:0] v,
			logic [DATA_W-1:0] d);
		return {d[9:5], v[10:8], d[4:0], v[2:0]};
	endfunction

	function automatic logic [2*WORD_W-1:0] build_block(logic [1:0] chip,
			logic [ADDR_W-1:0] field, logic [DATA_W-1:0] value);
		return {SERVICE_TAG, chip, STATUS_OK, field, value, 26'd0};
	endfunction

endpackage

/* hw/rtl/pcpr_channels.sv */
interface pcpr_req_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [pcpr_pkg::ADDR_W-1:0]   address;
	logic [pcpr_pkg::DATA_W-1:0]   data;

	modport source (output valid, func, address, data, input ready);
	modport sink (input valid, func, address, data, output ready);
endinterface

interface pcpr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pcpr_pkg::WORD_W-1:0]   word;
	logic                          last;

	modport source (output valid, word, last, input ready);
	modport sink (input valid, word, last, output ready);
endinterface

/* hw/rtl/pcpr_ctrl.sv */
module pcpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output pcpr_pkg::cmd_t    cmd,
	input  pcpr_pkg::sts_t    sts
);

	pcpr_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pcpr_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nx = pcpr_pkg::ST_IDLE;
			end
			pcpr_pkg::ST_IDLE: begin
				if (in_valid) state_nx = pcpr_pkg::ST_EXEC;
			end
			pcpr_pkg::ST_EXEC: begin
				unique case (sts.op)
					pcpr_pkg::OP_PMULTI: state_nx = pcpr_pkg::ST_MWR;
					pcpr_pkg::OP_READ:   state_nx = pcpr_pkg::ST_RDWAIT;
					default:             state_nx = pcpr_pkg::ST_IDLE;
				endcase
			end
			pcpr_pkg::ST_MRD: begin
				state_nx = pcpr_pkg::ST_MWR;
			end
			pcpr_pkg::ST_MWR: begin
				state_nx = sts.mw_last ? pcpr_pkg::ST_IDLE : pcpr_pkg::ST_MRD;
			end
			pcpr_pkg::ST_RDWAIT: begin
				if (sts.out_free) state_nx = pcpr_pkg::ST_IDLE;
			end
			default: state_nx = pcpr_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pcpr_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			pcpr_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take_item = in_valid;
			end
			pcpr_pkg::ST_EXEC: begin
				cmd.exec    = 1'b1;
				cmd.adv_row = (sts.op == pcpr_pkg::OP_PFULL);
			end
			pcpr_pkg::ST_MRD: begin
				cmd.mw_read = 1'b1;
			end
			pcpr_pkg::ST_MWR: begin
				cmd.mw_write = 1'b1;
				cmd.adv_row  = sts.mw_last;
			end
			pcpr_pkg::ST_RDWAIT: begin
				cmd.load_out = sts.out_free;
				cmd.adv_row  = sts.out_free & sts.portal;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/pcpr_dp.sv */
`include "pixel_config_portal_regs_core_defines.svh"

module pcpr_dp #(
	parameter int ROWS            = pcpr_pkg::ROWS_DEF,
	parameter int DOUBLE_COLUMNS  = pcpr_pkg::DOUBLE_COLUMNS_DEF,
	parameter int CORE_COLUMNS    = pcpr_pkg::CORE_COLUMNS_DEF,
	parameter int COLUMN_REG_ADDR = pcpr_pkg::COLUMN_REG_ADDR_DEF,
	parameter int ROW_REG_ADDR    = pcpr_pkg::ROW_REG_ADDR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pcpr_pkg::cmd_t                     cmd,
	output pcpr_pkg::sts_t                     sts,
	input  logic                               func,
	input  logic [pcpr_pkg::ADDR_W-1:0]        address,
	input  logic [pcpr_pkg::DATA_W-1:0]        data,
	input  logic                               cfg_we,
	input  logic [pcpr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [pcpr_pkg::WORD_W-1:0]        out_word,
	output logic                               out_last
);

	localparam int PAIRS     = ROWS * DOUBLE_COLUMNS;
	localparam int PA_W      = $clog2(PAIRS);
	localparam int CLEAR_LEN = (PAIRS > pcpr_pkg::GLOBAL_DEPTH) ? PAIRS
	                                                             : pcpr_pkg::GLOBAL_DEPTH;
	localparam int CW        = $clog2(CLEAR_LEN + 1);
	localparam int KW        = (CORE_COLUMNS > 1) ? $clog2(CORE_COLUMNS) : 1;
	localparam int RAW       = pcpr_pkg::REG_AW;

	localparam logic [PA_W-1:0]  ROWS_PA   = PA_W'(ROWS);
	localparam logic [PA_W:0]    PAIRS_V   = (PA_W+1)'(PAIRS);
	localparam logic [9:0]       ROWS_V    = 10'(ROWS);
	localparam logic [9:0]       DCOLS_V   = 10'(DOUBLE_COLUMNS);
	localparam logic [CW-1:0]    CLR_PAIRS = CW'(PAIRS);
	localparam logic [CW-1:0]    CLR_GLOB  = CW'(pcpr_pkg::GLOBAL_DEPTH);
	localparam logic [CW-1:0]    CLR_END   = CW'(CLEAR_LEN - 1);
	localparam logic [KW-1:0]    K_END     = KW'(CORE_COLUMNS - 1);
	localparam logic [RAW-1:0]   COL_ADDR  = RAW'(COLUMN_REG_ADDR);
	localparam logic [RAW-1:0]   ROW_ADDR  = RAW'(ROW_REG_ADDR);

	// configuration
	logic                          mode_tdac_q, broadcast_q, auto_row_q;
	logic [1:0]                    chip_id_q;

	// latched item
	logic                          func_q;
	logic [pcpr_pkg::ADDR_W-1:0]   addr_q;
	logic [pcpr_pkg::DATA_W-1:0]   data_q;

	// pointers and broadcast walk
	logic [pcpr_pkg::COL_W-1:0]    col_q;
	logic [pcpr_pkg::ROW_W-1:0]    row_q;
	logic [pcpr_pkg::BCOL_W-1:0]   bcol_q;
	logic [KW-1:0]                 k_q;

	// clearing pass
	logic [CW-1:0]                 clr_q;
	logic                          clr_done_q;

	// memories
	logic [pcpr_pkg::DATA_W-1:0]   pair_mem [PAIRS];
	logic [pcpr_pkg::DATA_W-1:0]   glob_mem [pcpr_pkg::GLOBAL_DEPTH];
	logic [pcpr_pkg::DATA_W-1:0]   pair_rd_q, glob_rd_q;

	// output stage
	logic                          out_valid_q, out_second_q;
	logic [2*pcpr_pkg::WORD_W-1:0] block_q;

	logic [RAW-1:0]                reg_a;
	logic                          portal;
	pcpr_pkg::op_t                 op;
	logic                          in_rng, mw_last;
	logic [PA_W-1:0]               pidx;
	logic [9:0]                    row_x, row_nx;
	logic                          pair_we, pair_re, glob_we, glob_re;
	logic [PA_W-1:0]               pair_wa;
	logic [PA_W:0]                 pair_wa_x;
	logic [pcpr_pkg::DATA_W-1:0]   pair_wd, mw_data, rd_value;
	logic [RAW-1:0]                glob_wa;
	logic [pcpr_pkg::DATA_W-1:0]   glob_wd;
	logic [pcpr_pkg::ADDR_W-1:0]   rd_field;
	logic                          rsp_take;

	assign reg_a  = addr_q[RAW-1:0];
	assign portal = (reg_a == '0);

	always_comb begin
		if (func_q == pcpr_pkg::FUNC_READ) begin
			op = pcpr_pkg::OP_READ;
		end else if (!portal) begin
			op = pcpr_pkg::OP_GWRITE;
		end else if (addr_q[pcpr_pkg::ADDR_W-1]) begin
			op = pcpr_pkg::OP_PMULTI;
		end else begin
			op = pcpr_pkg::OP_PFULL;
		end
	end

	assign row_x   = {1'b0, row_q};
	assign row_nx  = row_x + 10'd1;
	assign in_rng  = ({1'b0, bcol_q} < DCOLS_V) && (row_x < ROWS_V);
	assign pidx    = PA_W'(bcol_q) * ROWS_PA + PA_W'(row_q);
	assign mw_last = mode_tdac_q || !broadcast_q || (k_q == K_END);
	assign mw_data = mode_tdac_q ? pcpr_pkg::tdac_merge(pair_rd_q, data_q)
	                             : pcpr_pkg::mask_merge(pair_rd_q, data_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_tdac_q <= 1'b0;
			broadcast_q <= 1'b0;
			auto_row_q  <= 1'b0;
			chip_id_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcpr_pkg::CFG_MODE_TDAC: mode_tdac_q <= cfg_wdata[0];
				pcpr_pkg::CFG_BROADCAST: broadcast_q <= cfg_wdata[0];
				pcpr_pkg::CFG_AUTO_ROW:  auto_row_q  <= cfg_wdata[0];
				pcpr_pkg::CFG_CHIP_ID:   chip_id_q   <= cfg_wdata;
				default:                 chip_id_q   <= chip_id_q;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			func_q <= func;
			addr_q <= address;
			data_q <= data;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (cmd.exec && op == pcpr_pkg::OP_GWRITE) begin
				if (reg_a == COL_ADDR) col_q <= data_q[pcpr_pkg::COL_W-1:0];
				if (reg_a == ROW_ADDR) row_q <= data_q[pcpr_pkg::ROW_W-1:0];
			end
			if (cmd.adv_row && auto_row_q) begin
				row_q <= (row_nx >= ROWS_V) ? '0 : row_nx[pcpr_pkg::ROW_W-1:0];
			end
		end
	end

	// broadcast walk
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			bcol_q <= {1'b0, col_q};
			k_q    <= '0;
		end else if (cmd.mw_write && !mw_last) begin
			bcol_q <= bcol_q + pcpr_pkg::BCOL_W'(4);
			k_q    <= k_q + KW'(1);
		end
	end

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + CW'(1);
			if (clr_q == CLR_END) clr_done_q <= 1'b1;
		end
	end

	// write and read port selection
	always_comb begin
		pair_we = 1'b0;
		pair_wa = pidx;
		pair_wd = data_q;
		glob_we = 1'b0;
		glob_wa = reg_a;
		glob_wd = data_q;
		if (cmd.clr_step) begin
			pair_we = (clr_q < CLR_PAIRS);
			pair_wa = clr_q[PA_W-1:0];
			pair_wd = '0;
			glob_we = (clr_q < CLR_GLOB);
			glob_wa = clr_q[RAW-1:0];
			glob_wd = '0;
		end else if (cmd.exec && op == pcpr_pkg::OP_PFULL) begin
			pair_we = in_rng;
		end else if (cmd.exec && op == pcpr_pkg::OP_GWRITE) begin
			glob_we = 1'b1;
		end else if (cmd.mw_write) begin
			pair_we = in_rng;
			pair_wd = mw_data;
		end
	end

	assign pair_wa_x = {1'b0, pair_wa};
	assign pair_re   = cmd.mw_read || (cmd.exec && portal &&
	                   (op == pcpr_pkg::OP_PMULTI || op == pcpr_pkg::OP_READ));
	assign glob_re   = cmd.exec && !portal && op == pcpr_pkg::OP_READ;

	always_ff @(posedge clk) begin
		if (pair_we) pair_mem[pair_wa] <= pair_wd;
	end

	always_ff @(posedge clk) begin
		if (pair_re) pair_rd_q <= pair_mem[pidx];
	end

	always_ff @(posedge clk) begin
		if (glob_we) glob_mem[glob_wa] <= glob_wd;
	end

	always_ff @(posedge clk) begin
		if (glob_re) glob_rd_q <= glob_mem[reg_a];
	end

	// service block contents
	always_comb begin
		if (portal) begin
			rd_field = {1'b1, row_q};
			rd_value = in_rng ? pair_rd_q : '0;
		end else begin
			rd_field = {1'b0, reg_a};
			if (reg_a == COL_ADDR) begin
				rd_value = {{(pcpr_pkg::DATA_W-pcpr_pkg::COL_W){1'b0}}, col_q};
			end else if (reg_a == ROW_ADDR) begin
				rd_value = {{(pcpr_pkg::DATA_W-pcpr_pkg::ROW_W){1'b0}}, row_q};
			end else begin
				rd_value = glob_rd_q;
			end
		end
	end

	// output stage, upper word first
	assign rsp_take = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_second_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q  <= 1'b1;
			out_second_q <= 1'b0;
		end else if (rsp_take) begin
			if (out_second_q) begin
				out_valid_q <= 1'b0;
			end
			out_second_q <= !out_second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) block_q <= pcpr_pkg::build_block(chip_id_q, rd_field, rd_value);
	end

	assign out_valid = out_valid_q;
	assign out_last  = out_second_q;
	assign out_word  = out_second_q ? block_q[pcpr_pkg::WORD_W-1:0]
	                                : block_q[2*pcpr_pkg::WORD_W-1:pcpr_pkg::WORD_W];

	assign sts.clr_last = (clr_q == CLR_END);
	assign sts.op       = op;
	assign sts.portal   = portal;
	assign sts.mw_last  = mw_last;
	assign sts.out_free = !out_valid_q;

	`PCPR_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q)
	`PCPR_ASSERT_IMP(a_item_after_clear, clk, arst_n, cmd.take_item, clr_done_q)
	`PCPR_ASSERT_IMP(a_pair_addr, clk, arst_n, pair_we, pair_wa_x < PAIRS_V)
	`PCPR_ASSERT_NXT(a_second_word, clk, arst_n, rsp_take && !out_second_q, out_valid_q && out_second_q)
	`PCPR_ASSERT_NXT(a_row_wrap, clk, arst_n, cmd.adv_row && auto_row_q, row_x < ROWS_V)

endmodule

/* hw/rtl/pixel_config_portal_regs_core.sv */
// channel   role     handshake      payload
// req       sink     valid/ready    func, address[9:0], data[15:0]
// rsp       source   valid/ready    word[31:0], last
// cfg       write    cfg_we         cfg_index[1:0], cfg_wdata[1:0]
//
// one item at a time; ready is high only while the sequencer is idle
// global or full portal write: exec, then back to idle; read: exec, rdwait, then two words out
// multi-write: exec reads the pair, mwr writes the merge; a broadcast mask write repeats mrd, mwr per core column
// a read waits while the output register still holds an earlier block; writes go on
// after reset a clearing pass zeroes both stores, one entry a cycle, stepping over
// max(ROWS*DOUBLE_COLUMNS, 512) entries (76800 by default) with no item taken
module pixel_config_portal_regs_core #(
	parameter int ROWS            = pcpr_pkg::ROWS_DEF,
	parameter int DOUBLE_COLUMNS  = pcpr_pkg::DOUBLE_COLUMNS_DEF,
	parameter int CORE_COLUMNS    = pcpr_pkg::CORE_COLUMNS_DEF,
	parameter int COLUMN_REG_ADDR = pcpr_pkg::COLUMN_REG_ADDR_DEF,
	parameter int ROW_REG_ADDR    = pcpr_pkg::ROW_REG_ADDR_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pcpr_req_if.sink                        req,
	pcpr_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [pcpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// command and status between sequencer and datapath
	pcpr_pkg::cmd_t cmd;
	pcpr_pkg::sts_t sts;
	logic           in_ready;

	// sequencer: clearing pass, item decode, broadcast walk, output hand-off
	pcpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign req.ready = in_ready;

	// stores, pointers, configuration and the service block output register
	pcpr_dp #(
		.ROWS            (ROWS),
		.DOUBLE_COLUMNS  (DOUBLE_COLUMNS),
		.CORE_COLUMNS    (CORE_COLUMNS),
		.COLUMN_REG_ADDR (COLUMN_REG_ADDR),
		.ROW_REG_ADDR    (ROW_REG_ADDR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (req.func),
		.address   (req.address),
		.data      (req.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_word  (rsp.word),
		.out_last  (rsp.last)
	);

endmodule
